// ----- hdl/fdg_pkg.sv -----
// ----------------------------------------------------------------------------
// fdg_pkg
// Shared widths, register codes and the result record of the 2-D gradient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdg_pkg;

    // Gradient result and coefficient widths
    localparam int GRAD_W          = 25;
    localparam int INV_W           = 16;
    localparam int SHIFT_ONE_SIDED = 8;
    localparam int SHIFT_CENTRAL   = 9;

    // Frame geometry
    localparam int IMG_W_W = 11;
    localparam int IMG_H_W = 16;
    localparam int PROW_W  = 16;
    localparam int PCOL_W  = 10;

    // Configuration channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING  = 2'd2;

    localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd1024;
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd1024;
    localparam logic [INV_W-1:0]   INV_RESET   = 16'd256;

    // One input item causes at most this many results
    localparam int RES_SLOTS = 3;

    typedef struct packed {
        logic [GRAD_W-1:0] grad_row;
        logic [GRAD_W-1:0] grad_col;
        logic [PROW_W-1:0] prow;
        logic [PCOL_W-1:0] pcol;
        logic              done;
        logic              last;
    } result_t;

endpackage

// ----- hdl/fdg_scale.sv -----
// ----------------------------------------------------------------------------
// fdg_scale
// Multiplies a sample difference by the Q8.8 reciprocal spacing and floors
// the product by 8 bits (one-sided) or 9 bits (central difference).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdg_scale
    import fdg_pkg::*;
#(
    parameter int DIFF_W = 17
)
(
    input  logic signed [DIFF_W-1:0] diff,
    input  logic        [INV_W-1:0]  inv_spacing,
    input  logic                     central,
    output logic signed [GRAD_W-1:0] grad
);

    localparam int PROD_W = DIFF_W + INV_W + 1;

    logic signed [PROD_W-1:0]        product;
    logic signed [PROD_W-1:0]        shifted;
    logic        [PROD_W+GRAD_W-1:0] extended;

    assign product  = PROD_W'(diff) * PROD_W'($signed({1'b0, inv_spacing}));
    // arithmetic shift floors toward minus infinity
    assign shifted  = central ? (product >>> SHIFT_CENTRAL) : (product >>> SHIFT_ONE_SIDED);
    assign extended = {{GRAD_W{shifted[PROD_W-1]}}, shifted};
    assign grad     = $signed(extended[GRAD_W-1:0]);

endmodule

// ----- hdl/finite_difference_gradient_2d.sv -----
// Results: the first result of an item is registered in the input stage and then in the
// result buffer, from which the output port offers it.
// Throughput: one item per cycle while the output takes every result; on the frame's last
// row an item gives up to three results, which the single output port sends one by one.
// Reset: counters, pipeline valids and registers (width 1024, height 1024, spacing 256)
// are cleared at once; the two line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// finite_difference_gradient_2d
// Streaming central-difference gradient over a row-major frame, with
// one-sided differences on the frame edges and two line stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module finite_difference_gradient_2d
    import fdg_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [SAMPLE_BITS-1:0] sample, zero pad up to a whole byte
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [24:0] grad_row, [49:25] grad_col, [65:50] pixel_row, [75:66] pixel_col,
    // [79:76] zero
    output logic [79:0]           m_axis_tdata,
    output logic                  m_axis_tlast,     // frame_done
    output logic                  m_axis_tuser,     // [0] run_last

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int LW      = (IMG_W_W > CW + 1) ? IMG_W_W : CW + 1;
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int NPROD   = 2 * RES_SLOTS;
    localparam int FIELD_W = 2 * GRAD_W + PROW_W + PCOL_W;
    localparam int PAD_W   = 80 - FIELD_W;

    typedef struct packed {
        logic row_first;
        logic row_second;
        logic row_last;
        logic col_first;
        logic col_second;
        logic col_last;
    } pos_t;

    // Configuration
    logic [IMG_W_W-1:0] img_w_reg;
    logic [IMG_H_W-1:0] img_h_reg;
    logic [INV_W-1:0]   inv_reg;

    // Position and history
    logic [CW-1:0]                 col_reg;
    logic [IMG_H_W-1:0]            row_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic signed [SAMPLE_BITS-1:0] pprev_reg;

    logic [LW-1:0]      w_ext;
    logic [LW-1:0]      w_use;
    logic [IMG_H_W-1:0] h_use;
    logic               restart;
    logic [CW-1:0]      col_cur;
    logic [CW-1:0]      col_up;
    logic [IMG_H_W-1:0] row_cur;
    logic               last_col;
    logic               last_row;
    logic [CW-1:0]      col_next;
    logic [IMG_H_W-1:0] row_next;
    pos_t               pos_cur;

    logic                          in_accept;
    logic                          out_accept;
    logic signed [SAMPLE_BITS-1:0] sample;

    // Line stores
    logic signed [SAMPLE_BITS-1:0] newer_mem [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] older_mem [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] newer_rd_reg;
    logic signed [SAMPLE_BITS-1:0] newer_up_rd_reg;
    logic signed [SAMPLE_BITS-1:0] older_rd_reg;
    logic                          older_wr_reg;
    logic [CW-1:0]                 older_addr_reg;

    // Input stage
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic signed [SAMPLE_BITS-1:0] s1_prev_reg;
    logic signed [SAMPLE_BITS-1:0] s1_pprev_reg;
    logic signed [SAMPLE_BITS-1:0] s1_left_reg;
    logic [CW-1:0]                 s1_col_reg;
    logic [IMG_H_W-1:0]            s1_row_reg;
    pos_t                          s1_pos_reg;

    logic signed [DIFF_W-1:0] s_x;
    logic signed [DIFF_W-1:0] p_x;
    logic signed [DIFF_W-1:0] pp_x;
    logic signed [DIFF_W-1:0] left_x;
    logic signed [DIFF_W-1:0] nc_x;
    logic signed [DIFF_W-1:0] nc1_x;
    logic signed [DIFF_W-1:0] oc_x;
    logic signed [DIFF_W-1:0] diff_arr    [NPROD];
    logic                     central_arr [NPROD];
    logic signed [GRAD_W-1:0] grad_arr    [NPROD];

    logic [CW-1:0]          s1_col_m1;
    logic [PCOL_W+CW-1:0]   pcol_here_ext;
    logic [PCOL_W+CW-1:0]   pcol_left_ext;
    logic [RES_SLOTS-1:0]   mask_new;
    result_t                res_new [RES_SLOTS];

    // Result buffer
    result_t              res_reg [RES_SLOTS];
    logic [RES_SLOTS-1:0] res_mask_reg;
    logic [RES_SLOTS-1:0] res_mask_next;
    logic [RES_SLOTS-1:0] res_lowest;
    logic [RES_SLOTS-1:0] res_after;
    logic [1:0]           res_sel;
    logic                 buf_free;
    logic                 load;
    result_t              out_entry;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign sample     = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign cfg_ready  = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= IMG_W_RESET;
            img_h_reg <= IMG_H_RESET;
            inv_reg   <= INV_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  img_w_reg <= cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: img_h_reg <= cfg_data[IMG_H_W-1:0];
                REG_INV_SPACING:  inv_reg   <= cfg_data[INV_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame position of the arriving item
    // ------------------------------------------------------------------
    always_comb
    begin
        w_ext = LW'(img_w_reg);
        if (w_ext < LW'(2))
            w_use = LW'(2);
        else if (w_ext > LW'(MAX_WIDTH))
            w_use = LW'(MAX_WIDTH);
        else
            w_use = w_ext;

        h_use = (img_h_reg < IMG_H_W'(2)) ? IMG_H_W'(2) : img_h_reg;

        // counters left beyond a shrunk frame start over at the origin
        restart = (LW'(col_reg) >= w_use) || (row_reg >= h_use);
        col_cur = restart ? '0 : col_reg;
        row_cur = restart ? '0 : row_reg;
        col_up  = (col_cur == CW'(MAX_WIDTH - 1)) ? '0 : col_cur + CW'(1);

        last_col = (LW'(col_cur) == w_use - LW'(1));
        last_row = (row_cur == h_use - IMG_H_W'(1));

        col_next = last_col ? '0 : col_up;
        if (last_col)
            row_next = last_row ? '0 : row_cur + IMG_H_W'(1);
        else
            row_next = row_cur;

        pos_cur.row_first  = (row_cur == '0);
        pos_cur.row_second = (row_cur == IMG_H_W'(1));
        pos_cur.row_last   = last_row;
        pos_cur.col_first  = (col_cur == '0);
        pos_cur.col_second = (col_cur == CW'(1));
        pos_cur.col_last   = last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            prev_reg  <= '0;
            pprev_reg <= '0;
        end
        else if (in_accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            prev_reg  <= sample;
            pprev_reg <= prev_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: newer is read at c and c+1, older at c. The older row
    // takes the newer entry in the cycle after, once its read data is back.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            newer_rd_reg       <= newer_mem[col_cur];
            newer_up_rd_reg    <= newer_mem[col_up];
            newer_mem[col_cur] <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            older_rd_reg <= older_mem[col_cur];
        if (older_wr_reg)
            older_mem[older_addr_reg] <= newer_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            older_wr_reg <= 1'b0;
        else
            older_wr_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            older_addr_reg <= col_cur;
    end

    // ------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------
    assign s_axis_tready = !s1_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (load)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= sample;
            s1_prev_reg   <= prev_reg;
            s1_pprev_reg  <= pprev_reg;
            // newer entry of the previous column, now the older one there
            s1_left_reg   <= newer_rd_reg;
            s1_col_reg    <= col_cur;
            s1_row_reg    <= row_cur;
            s1_pos_reg    <= pos_cur;
        end
    end

    // ------------------------------------------------------------------
    // Differences for the up to three pixels this item completes
    // ------------------------------------------------------------------
    always_comb
    begin
        s_x    = DIFF_W'(s1_sample_reg);
        p_x    = DIFF_W'(s1_prev_reg);
        pp_x   = DIFF_W'(s1_pprev_reg);
        left_x = DIFF_W'(s1_left_reg);
        nc_x   = DIFF_W'(newer_rd_reg);
        nc1_x  = DIFF_W'(newer_up_rd_reg);
        oc_x   = DIFF_W'(older_rd_reg);

        // pixel one row up
        if (s1_pos_reg.row_second)
        begin
            diff_arr[0]    = s_x - nc_x;
            central_arr[0] = 1'b0;
        end
        else
        begin
            diff_arr[0]    = s_x - oc_x;
            central_arr[0] = 1'b1;
        end

        if (s1_pos_reg.col_first)
        begin
            diff_arr[1]    = nc1_x - nc_x;
            central_arr[1] = 1'b0;
        end
        else if (s1_pos_reg.col_last)
        begin
            diff_arr[1]    = nc_x - left_x;
            central_arr[1] = 1'b0;
        end
        else
        begin
            diff_arr[1]    = nc1_x - left_x;
            central_arr[1] = 1'b1;
        end

        // last row: pixel to the left
        diff_arr[2]    = p_x - left_x;
        central_arr[2] = 1'b0;
        if (s1_pos_reg.col_second)
        begin
            diff_arr[3]    = s_x - p_x;
            central_arr[3] = 1'b0;
        end
        else
        begin
            diff_arr[3]    = s_x - pp_x;
            central_arr[3] = 1'b1;
        end

        // last row, last column: this pixel
        diff_arr[4]    = s_x - nc_x;
        central_arr[4] = 1'b0;
        diff_arr[5]    = s_x - p_x;
        central_arr[5] = 1'b0;
    end

    for (genvar g = 0; g < NPROD; g++)
    begin : g_scale
        fdg_scale #(
            .DIFF_W (DIFF_W)
        ) u_scale (
            .diff        (diff_arr[g]),
            .inv_spacing (inv_reg),
            .central     (central_arr[g]),
            .grad        (grad_arr[g])
        );
    end

    always_comb
    begin
        s1_col_m1     = s1_col_reg - CW'(1);
        pcol_here_ext = {{PCOL_W{1'b0}}, s1_col_reg};
        pcol_left_ext = {{PCOL_W{1'b0}}, s1_col_m1};

        mask_new[0] = !s1_pos_reg.row_first;
        mask_new[1] = s1_pos_reg.row_last && !s1_pos_reg.col_first;
        mask_new[2] = s1_pos_reg.row_last && s1_pos_reg.col_last;

        res_new[0].grad_row = grad_arr[0];
        res_new[0].grad_col = grad_arr[1];
        res_new[0].prow     = s1_row_reg - PROW_W'(1);
        res_new[0].pcol     = pcol_here_ext[PCOL_W-1:0];
        res_new[0].done     = 1'b0;
        res_new[0].last     = !mask_new[1] && !mask_new[2];

        res_new[1].grad_row = grad_arr[2];
        res_new[1].grad_col = grad_arr[3];
        res_new[1].prow     = s1_row_reg;
        res_new[1].pcol     = pcol_left_ext[PCOL_W-1:0];
        res_new[1].done     = 1'b0;
        res_new[1].last     = !mask_new[2];

        res_new[2].grad_row = grad_arr[4];
        res_new[2].grad_col = grad_arr[5];
        res_new[2].prow     = s1_row_reg;
        res_new[2].pcol     = pcol_here_ext[PCOL_W-1:0];
        res_new[2].done     = 1'b1;
        res_new[2].last     = 1'b1;
    end

    // ------------------------------------------------------------------
    // Result buffer: drains lowest slot first, refills once it empties
    // ------------------------------------------------------------------
    always_comb
    begin
        res_lowest = res_mask_reg & (~res_mask_reg + RES_SLOTS'(1));
        if (res_lowest[0])
            res_sel = 2'd0;
        else if (res_lowest[1])
            res_sel = 2'd1;
        else
            res_sel = 2'd2;

        res_after     = out_accept ? (res_mask_reg & ~res_lowest) : res_mask_reg;
        buf_free      = (res_after == '0);
        load          = s1_valid_reg && buf_free;
        res_mask_next = load ? mask_new : res_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_mask_reg <= '0;
        else
            res_mask_reg <= res_mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < RES_SLOTS; i++)
                res_reg[i] <= res_new[i];
        end
    end

    assign out_entry     = res_reg[res_sel];
    assign m_axis_tvalid = (res_mask_reg != '0);
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_entry.pcol, out_entry.prow,
                            out_entry.grad_col, out_entry.grad_row};
    assign m_axis_tlast  = out_entry.done;
    assign m_axis_tuser  = out_entry.last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("frame end result is not the last of its item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (out_entry.prow == h_use - PROW_W'(1)))
        else $error("frame end flagged off the last row");

    assert property (@(posedge clk) disable iff (!rst_n)
        (older_wr_reg && in_accept) |-> (col_cur != older_addr_reg))
        else $error("older line write collides with a read of the same column");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !load) |=> (s1_valid_reg && $stable(s1_col_reg)
                                     && $stable(s1_row_reg)))
        else $error("input stage item lost while the result buffer is full");

endmodule

// ----- tb/gradient_checker.sv -----
// ----------------------------------------------------------------------------
// gradient_checker
// Watches the sample, result and register channels of the 2-D gradient block,
// predicts the gradients of every accepted sample and compares each result
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_checker
    import fdg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,

    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [79:0]           m_axis_tdata,
    input  logic                  m_axis_tlast,
    input  logic                  m_axis_tuser,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    mismatches,
    output int                    outstanding
);

    localparam int LINE_DEPTH = 1024;

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [INV_W-1:0]   spacing_reg;

    logic signed [15:0] prior_row  [0:LINE_DEPTH-1];
    logic signed [15:0] recent_row [0:LINE_DEPTH-1];
    int                 row_pos;
    int                 col_pos;
    logic signed [15:0] last_sample;
    logic signed [15:0] second_last_sample;

    result_t            expected_gradients [$];
    result_t            want;
    result_t            got;
    int                 fail_tally;

    function automatic longint span(input logic signed [15:0] a,
                                    input logic signed [15:0] b);
        return longint'(a) - longint'(b);
    endfunction

    // Scale by the Q8.8 spacing, floor on the shift, wrap to the field width
    function automatic logic [GRAD_W-1:0] weighted(input longint diff, input int shift);
        longint      prod;
        logic [63:0] shifted;
        prod    = diff * longint'(spacing_reg);
        shifted = prod >>> shift;
        return shifted[GRAD_W-1:0];
    endfunction

    task automatic post(input logic [GRAD_W-1:0] gr, input logic [GRAD_W-1:0] gc,
                        input int r, input int c, input logic done);
        result_t res;
        res.grad_row = gr;
        res.grad_col = gc;
        res.prow     = r[PROW_W-1:0];
        res.pcol     = c[PCOL_W-1:0];
        res.done     = done;
        res.last     = 1'b0;
        expected_gradients.push_back(res);
    endtask

    task automatic predict_gradients(input logic signed [15:0] s);
        int                w;
        int                h;
        int                r;
        int                c;
        int                queued;
        logic [GRAD_W-1:0] gr;
        logic [GRAD_W-1:0] gc;
        w = width_reg;
        h = height_reg;
        if (w < 2)
            w = 2;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        if (h < 2)
            h = 2;
        // restart the frame when a new size leaves the counters outside it
        if (col_pos >= w || row_pos >= h)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        r      = row_pos;
        c      = col_pos;
        queued = expected_gradients.size();

        if (r >= 1)
        begin
            // pixel one row up
            if (r == 1)
                gr = weighted(span(s, recent_row[c]), SHIFT_ONE_SIDED);
            else
                gr = weighted(span(s, prior_row[c]), SHIFT_CENTRAL);
            if (c == 0)
                gc = weighted(span(recent_row[1], recent_row[0]), SHIFT_ONE_SIDED);
            else if (c == w - 1)
                gc = weighted(span(recent_row[c], prior_row[c-1]), SHIFT_ONE_SIDED);
            else
                gc = weighted(span(recent_row[c+1], prior_row[c-1]), SHIFT_CENTRAL);
            post(gr, gc, r - 1, c, 1'b0);

            if (r == h - 1)
            begin
                // last row: the pixel to the left, and the corner at the row's end
                if (c >= 1)
                begin
                    gr = weighted(span(last_sample, prior_row[c-1]), SHIFT_ONE_SIDED);
                    if (c == 1)
                        gc = weighted(span(s, last_sample), SHIFT_ONE_SIDED);
                    else
                        gc = weighted(span(s, second_last_sample), SHIFT_CENTRAL);
                    post(gr, gc, r, c - 1, 1'b0);
                end
                if (c == w - 1)
                begin
                    gr = weighted(span(s, recent_row[c]), SHIFT_ONE_SIDED);
                    gc = weighted(span(s, last_sample), SHIFT_ONE_SIDED);
                    post(gr, gc, r, c, 1'b1);
                end
            end
        end

        prior_row[c]       = recent_row[c];
        recent_row[c]      = s;
        second_last_sample = last_sample;
        last_sample        = s;

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;

        if (expected_gradients.size() > queued)
            expected_gradients[expected_gradients.size()-1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] exp_val,
                               input logic signed [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg          = IMG_W_RESET;
            height_reg         = IMG_H_RESET;
            spacing_reg        = INV_RESET;
            row_pos            = 0;
            col_pos            = 0;
            last_sample        = '0;
            second_last_sample = '0;
            fail_tally         = 0;
            expected_gradients.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.grad_row = m_axis_tdata[24:0];
                got.grad_col = m_axis_tdata[49:25];
                got.prow     = m_axis_tdata[65:50];
                got.pcol     = m_axis_tdata[75:66];
                got.done     = m_axis_tlast;
                got.last     = m_axis_tuser;
                if (expected_gradients.size() == 0)
                begin
                    $error("unexpected result for pixel row %0d col %0d", got.prow, got.pcol);
                    fail_tally++;
                end
                else
                begin
                    want = expected_gradients.pop_front();
                    check_field("grad_row", $signed(want.grad_row), $signed(got.grad_row));
                    check_field("grad_col", $signed(want.grad_col), $signed(got.grad_col));
                    check_field("pixel_row", want.prow, got.prow);
                    check_field("pixel_col", want.pcol, got.pcol);
                    check_field("frame_done", want.done, got.done);
                    check_field("run_last", want.last, got.last);
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg   = cfg_data[IMG_W_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg  = cfg_data[IMG_H_W-1:0];
                    REG_INV_SPACING:  spacing_reg = cfg_data[INV_W-1:0];
                    default:          ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                predict_gradients(s_axis_tdata);

            mismatches  <= fail_tally;
            outstanding <= expected_gradients.size();
        end
    end

endmodule

// ----- tb/tb_finite_difference_gradient_2d.sv -----
// ----------------------------------------------------------------------------
// tb_finite_difference_gradient_2d
// Drives sample frames and register writes into the 2-D gradient block under
// random idling on both streams; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_finite_difference_gradient_2d;
    import fdg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int RANDOM_ITEMS  = 80;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_COLS      = 1024;

    logic                  clk;
    logic                  rst_n;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [79:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatches;
    int                    outstanding;

    // frame position as the block will see it at the next sample
    int                    eff_w;
    int                    eff_h;
    int                    pos_row;
    int                    pos_col;
    bit                    tx_quiet;
    bit                    rx_quiet;
    int                    idle_cycles;

    finite_difference_gradient_2d u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gradient_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_sample(input logic [15:0] value);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        if (pos_col >= eff_w || pos_row >= eff_h)
        begin
            pos_col = 0;
            pos_row = 0;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (pos_col + 1 >= eff_w)
        begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= eff_h) ? 0 : pos_row + 1;
        end
        else
            pos_col++;
    endtask

    task automatic send_run(input int count);
        for (int i = 0; i < count; i++)
            send_sample(pick_sample());
    endtask

    // Hold the sample stream until every predicted result is out, then let the
    // pipeline run dry.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:
            begin
                eff_w = value[IMG_W_W-1:0];
                if (eff_w < 2)
                    eff_w = 2;
                if (eff_w > MAX_COLS)
                    eff_w = MAX_COLS;
            end
            REG_IMAGE_HEIGHT: eff_h = (value < 2) ? 2 : value;
            default:          ;
        endcase
    endtask

    initial
    begin
        logic [15:0] corner_frame [0:8];
        int          w_new;
        int          h_new;
        int          inv_new;
        int          count;
        int          random_sent;
        bit          drained;

        corner_frame = '{16'h7FFF, 16'h8000, 16'h7FFF,
                         16'h7FFF, 16'h0000, 16'h8000,
                         16'h8000, 16'hFFFF, 16'h7FFF};
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_IMAGE_WIDTH;
        cfg_data      <= '0;
        rst_n         <= 1'b0;
        eff_w         = MAX_COLS;
        eff_h         = IMG_H_RESET;
        pos_row       = 0;
        pos_col       = 0;
        tx_quiet      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: part of a wide first row, then a narrow width restarts it
        send_run(3);
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'd2);
        cfg_valid <= 1'b0;
        send_run(4);

        // spare index, wide width value, height below the minimum, zero spacing
        settle();
        write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
        write_reg(REG_IMAGE_WIDTH, 16'hF802);
        write_reg(REG_IMAGE_HEIGHT, 16'h0000);
        write_reg(REG_INV_SPACING, 16'h0000);
        cfg_valid <= 1'b0;
        send_run(4);

        // full-scale swings through a 3x3 frame at the largest spacing
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        write_reg(REG_INV_SPACING, 16'hFFFF);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 9; i++)
            send_sample(corner_frame[i]);

        // widest and tallest frame, cut short by a narrower width
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'h07FF);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(REG_INV_SPACING, 16'd1);
        cfg_valid <= 1'b0;
        send_run(3);
        settle();
        write_reg(REG_IMAGE_WIDTH, 16'd2);
        cfg_valid <= 1'b0;
        send_run(6);

        random_sent = 0;
        drained     = 1'b0;
        while (random_sent < RANDOM_ITEMS)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            w_new    = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24)
                                                   : $urandom_range(2, 8);
            h_new    = $urandom_range(2, 5);
            case ($urandom_range(0, 5))
                0:       inv_new = 0;
                1:       inv_new = 65535;
                default: inv_new = $urandom_range(1, 65535);
            endcase
            // a frame left open must restart, never grow under the line stores
            if ((pos_row != 0 || pos_col != 0) && pos_col < w_new && pos_row < h_new)
            begin
                if (pos_col >= 2)
                    w_new = $urandom_range(2, pos_col);
                else
                    h_new = $urandom_range(2, pos_row);
            end
            settle();
            write_reg(REG_IMAGE_WIDTH, 16'(w_new));
            write_reg(REG_IMAGE_HEIGHT, 16'(h_new));
            write_reg(REG_INV_SPACING, 16'(inv_new));
            cfg_valid <= 1'b0;

            count = w_new * h_new * $urandom_range(1, 2);
            for (int i = 0; i < count; i++)
            begin
                if (!drained && i == count / 2)
                begin
                    settle();
                    drained = 1'b1;
                end
                send_sample(pick_sample());
            end
            random_sent += count;

            // now and then leave a frame open for the next setting to cut off
            if ($urandom_range(0, 3) == 0)
            begin
                count = $urandom_range(2, w_new * h_new - 1);
                send_run(count);
                random_sent += count;
                while (pos_col < 2 && pos_row < 2 && (pos_row != 0 || pos_col != 0))
                begin
                    send_sample(pick_sample());
                    random_sent++;
                end
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // result side: random stall before each item, with quiet stretches
    initial
    begin
        int stall;
        int served;
        m_axis_tready <= 1'b0;
        rx_quiet = 1'b0;
        served   = 0;
        @(posedge rst_n);
        forever
        begin
            if (served % 16 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            served++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ----- sim.f -----
hdl/fdg_pkg.sv
hdl/fdg_scale.sv
hdl/finite_difference_gradient_2d.sv
tb/gradient_checker.sv
tb/tb_finite_difference_gradient_2d.sv
